### sv/dstc_pkg.sv
package dstc_pkg;

   // default field widths
   localparam int ANGLE_BITS_DEF = 16;
   localparam int SPEED_BITS_DEF = 16;

   // configuration register indexes
   localparam int CSR_INDEX_BITS = 3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STRAIGHT_HALF_ANGLE = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CLEARANCE_LIMIT     = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_AVOID_SPEED         = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_SPEED           = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HARD_TURN_ANGLE     = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SOFT_TURN_ANGLE     = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NO_TURN_ANGLE       = 3'd6;

   // register reset values
   localparam int RST_STRAIGHT_HALF_ANGLE = 1820;
   localparam int RST_CLEARANCE_LIMIT     = 2048;
   localparam int RST_AVOID_SPEED         = 640;
   localparam int RST_MAX_SPEED           = 2560;
   localparam int RST_HARD_TURN_ANGLE     = 16384;
   localparam int RST_SOFT_TURN_ANGLE     = 12743;
   localparam int RST_NO_TURN_ANGLE       = 1820;

   // turn mode codes
   localparam int MODE_BITS = 2;
   localparam logic [MODE_BITS-1:0] MODE_STRAIGHT = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_SOFT     = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_HARD     = 2'd2;

   typedef struct packed {
      logic load;      // capture the accepted input beat
      logic eval;      // update mode, register the product
      logic div_step;  // one quotient bit
      logic out_load;  // write the result register
   } dstc_cmd_type;

   typedef struct packed {
      logic use_div;   // soft turn with nonzero hard angle: run the divider
   } dstc_status_type;

endpackage

### sv/dstc_ctrl.sv
module dstc_ctrl #(
   parameter int DIV_STEPS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output dstc_pkg::dstc_cmd_type    cmd,
   input  dstc_pkg::dstc_status_type status
);
   import dstc_pkg::*;

   localparam int CNT_BITS = $clog2(DIV_STEPS);
   localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(DIV_STEPS - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DIV,
      ST_FINISH
   } state_type;

   state_type           state_ff, state_in;
   logic [CNT_BITS-1:0] div_cnt_ff, div_cnt_in;
   logic                rsp_tvalid_ff, rsp_tvalid_in;
   logic                slot_free;

   assign slot_free  = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;

   always_comb begin
      state_in      = state_ff;
      div_cnt_in    = div_cnt_ff;
      cmd           = '0;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cmd.eval   = 1'b1;
            div_cnt_in = '0;
            state_in   = status.use_div ? ST_DIV : ST_FINISH;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            div_cnt_in   = div_cnt_ff + 1'b1;
            if (div_cnt_ff == CNT_LAST) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // hold the result until the output register drains
            if (slot_free) begin
               cmd.out_load  = 1'b1;
               rsp_tvalid_in = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         div_cnt_ff    <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         div_cnt_ff    <= div_cnt_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

`ifndef SYNTHESIS
   ap_accept_eval: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff == ST_EVAL)
      else $error("accepted beat not followed by evaluation");
   ap_skip_div: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EVAL && !status.use_div |=> state_ff == ST_FINISH)
      else $error("divider entered without a soft turn");
   ap_div_end: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV && div_cnt_ff == CNT_LAST |=> state_ff == ST_FINISH)
      else $error("divider did not stop after the last quotient bit");
`endif

endmodule

### sv/dstc_dp.sv
module dstc_dp #(
   parameter int ANGLE_BITS = dstc_pkg::ANGLE_BITS_DEF,
   parameter int SPEED_BITS = dstc_pkg::SPEED_BITS_DEF,
   parameter int CSR_DATA_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [dstc_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [CSR_DATA_BITS-1:0]              csr_data,
   input  logic signed [ANGLE_BITS-1:0]          heading_angle,
   input  logic [SPEED_BITS-1:0]                 heading_length,
   input  logic signed [ANGLE_BITS-1:0]          obstacle_angle,
   input  logic [SPEED_BITS-1:0]                 obstacle_length,
   input  dstc_pkg::dstc_cmd_type                cmd,
   output dstc_pkg::dstc_status_type             status,
   output logic signed [SPEED_BITS+1:0]          left_speed,
   output logic signed [SPEED_BITS+1:0]          right_speed,
   output logic [dstc_pkg::MODE_BITS-1:0]        mode_now,
   output logic                                  avoiding
);
   import dstc_pkg::*;

   localparam int A  = ANGLE_BITS;
   localparam int S  = SPEED_BITS;
   localparam int PW = S + A;          // product and quotient width
   localparam int W  = PW + 2;         // signed width before saturation
   localparam int OW = S + 2;
   localparam logic signed [W-1:0] OUT_MAX_W = W'((64'd1 << (S + 1)) - 64'd1);
   localparam logic signed [W-1:0] OUT_MIN_W = -OUT_MAX_W - W'(1);

   // configuration registers
   logic [A-2:0] alpha_ff, hard_ff, soft_ff, none_ff;
   logic [S-1:0] clear_ff, avoid_ff, max_ff;

   // captured input beat
   logic signed [A-1:0] ha_ff, oa_ff;
   logic [S-1:0]        hlen_ff, olen_ff;

   // evaluation results
   logic [MODE_BITS-1:0] turn_mode_ff, turn_mode_in;
   logic                 steer_ff, use_div_ff, ha_pos_ff, oa_pos_ff;
   logic [S-1:0]         base_ff;

   // divider
   logic [PW-1:0] quo_ff, quo_in;
   logic [A-2:0]  rem_ff, rem_in;
   logic [A-1:0]  shifted, diff;
   logic          ge;

   // result register
   logic signed [OW-1:0] left_ff, right_ff;
   logic [MODE_BITS-1:0] mode_ff;
   logic                 avoiding_ff;

   // evaluation logic
   logic signed [A:0]    oa_ext, alpha_ext;
   logic                 steer;
   logic [A-1:0]         ha_u, mag;
   logic [S-1:0]         base;
   logic [MODE_BITS-1:0] m;
   logic [PW-1:0]        product;

   // finish logic
   logic signed [W-1:0]  base_w, d_w, s1, s2, left_w, right_w;
   logic signed [OW-1:0] left_in, right_in;

   function automatic logic signed [OW-1:0] sat(input logic signed [W-1:0] v);
      logic signed [OW-1:0] r;
      if (v > OUT_MAX_W) begin
         r = OUT_MAX_W[OW-1:0];
      end else if (v < OUT_MIN_W) begin
         r = OUT_MIN_W[OW-1:0];
      end else begin
         r = v[OW-1:0];
      end
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= (A-1)'(RST_STRAIGHT_HALF_ANGLE);
         clear_ff <= S'(RST_CLEARANCE_LIMIT);
         avoid_ff <= S'(RST_AVOID_SPEED);
         max_ff   <= S'(RST_MAX_SPEED);
         hard_ff  <= (A-1)'(RST_HARD_TURN_ANGLE);
         soft_ff  <= (A-1)'(RST_SOFT_TURN_ANGLE);
         none_ff  <= (A-1)'(RST_NO_TURN_ANGLE);
      end else if (csr_we) begin
         case (csr_index)
            CSR_STRAIGHT_HALF_ANGLE: alpha_ff <= csr_data[A-2:0];
            CSR_CLEARANCE_LIMIT:     clear_ff <= csr_data[S-1:0];
            CSR_AVOID_SPEED:         avoid_ff <= csr_data[S-1:0];
            CSR_MAX_SPEED:           max_ff   <= csr_data[S-1:0];
            CSR_HARD_TURN_ANGLE:     hard_ff  <= csr_data[A-2:0];
            CSR_SOFT_TURN_ANGLE:     soft_ff  <= csr_data[A-2:0];
            CSR_NO_TURN_ANGLE:       none_ff  <= csr_data[A-2:0];
            default: ;
         endcase
      end
   end

   // obstacle band test, heading magnitude, mode update
   always_comb begin
      oa_ext    = {oa_ff[A-1], oa_ff};
      alpha_ext = $signed({2'b00, alpha_ff});
      steer     = (oa_ext >= -alpha_ext) && (oa_ext <= alpha_ext) && (olen_ff < clear_ff);
      ha_u      = ha_ff;
      mag       = ha_ff[A-1] ? (~ha_u + 1'b1) : ha_u;
      base      = (hlen_ff < max_ff) ? hlen_ff : max_ff;

      m = turn_mode_ff;
      if (m == MODE_HARD && mag <= {1'b0, soft_ff}) begin
         m = MODE_SOFT;
      end
      if (m == MODE_SOFT) begin
         if (mag > {1'b0, hard_ff}) begin
            m = MODE_HARD;
         end else if (mag <= {1'b0, none_ff}) begin
            m = MODE_STRAIGHT;
         end
      end
      if (m == MODE_STRAIGHT) begin
         if (mag > {1'b0, hard_ff}) begin
            m = MODE_HARD;
         end else if (mag > {1'b0, none_ff}) begin
            m = MODE_SOFT;
         end
      end
      turn_mode_in   = steer ? m : turn_mode_ff;
      status.use_div = steer && (m == MODE_SOFT) && (hard_ff != '0);
      product        = PW'(base) * PW'(mag);
   end

   // restoring divider, one quotient bit per step
   always_comb begin
      shifted = {rem_ff, quo_ff[PW-1]};
      ge      = shifted >= {1'b0, hard_ff};
      diff    = shifted - {1'b0, hard_ff};
      rem_in  = ge ? diff[A-2:0] : shifted[A-2:0];
      quo_in  = {quo_ff[PW-2:0], ge};
   end

   // wheel speeds
   always_comb begin
      base_w = W'(base_ff);
      d_w    = use_div_ff ? W'(quo_ff) : '0;
      case (turn_mode_ff)
         MODE_SOFT: begin
            s1 = base_w - d_w;
            s2 = base_w + d_w;
         end
         MODE_HARD: begin
            s1 = -W'(max_ff);
            s2 = W'(max_ff);
         end
         default: begin
            s1 = base_w;
            s2 = base_w;
         end
      endcase
      if (!steer_ff) begin
         left_w  = oa_pos_ff ? W'(avoid_ff) : '0;
         right_w = oa_pos_ff ? '0 : W'(avoid_ff);
      end else if (ha_pos_ff) begin
         left_w  = s1;
         right_w = s2;
      end else begin
         left_w  = s2;
         right_w = s1;
      end
      left_in  = sat(left_w);
      right_in = sat(right_w);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         turn_mode_ff <= MODE_STRAIGHT;
      end else if (cmd.eval) begin
         turn_mode_ff <= turn_mode_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ha_ff   <= heading_angle;
         hlen_ff <= heading_length;
         oa_ff   <= obstacle_angle;
         olen_ff <= obstacle_length;
      end
      if (cmd.eval) begin
         steer_ff   <= steer;
         use_div_ff <= status.use_div;
         ha_pos_ff  <= !ha_ff[A-1] && (ha_ff != '0);
         oa_pos_ff  <= !oa_ff[A-1] && (oa_ff != '0);
         base_ff    <= base;
         quo_ff     <= product;
         rem_ff     <= '0;
      end else if (cmd.div_step) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
      if (cmd.out_load) begin
         left_ff     <= left_in;
         right_ff    <= right_in;
         mode_ff     <= turn_mode_ff;
         avoiding_ff <= !steer_ff;
      end
   end

   assign left_speed  = left_ff;
   assign right_speed = right_ff;
   assign mode_now    = mode_ff;
   assign avoiding    = avoiding_ff;

`ifndef SYNTHESIS
   ap_pivot_keeps_mode: assert property (@(posedge clock) disable iff (reset)
      cmd.eval && !steer |=> turn_mode_ff == $past(turn_mode_ff))
      else $error("pivot branch changed the turn mode");
`endif

endmodule

### sv/differential_steering_turn_controller_top.sv
// Differential-drive turn controller: heading and obstacle vectors in, wheel
// speeds out, with a three-state (straight / soft / hard) turn mode kept
// between beats.
// req_ channel: one beat per control step; tdata carries heading angle and
//   length, obstacle angle and length. req_tready is high only while the
//   block is idle, so it works on one beat at a time.
// rsp_ channel: one beat per request; tdata carries left and right speed
//   (signed Q10.8, saturated), tuser carries the turn mode and the pivot flag.
// csr_ channel: register writes, always ready; write only while idle.
// Sequence: an accepted beat is evaluated and its result then loaded into
//   the output register; a soft turn with a nonzero hard turn angle runs
//   the bit-serial divider between the two, which forms the speed difference
//   one quotient bit per step. The next request is taken once the block is
//   back in idle after the result enters the output register.
// Stall: the result waits in the output register while rsp_tready is low;
//   a new request may be taken meanwhile, and its result holds in the
//   datapath until the register drains.
// Reset (synchronous, active high): registers return to their defaults, the
//   turn mode returns to straight and both channels go empty.
module differential_steering_turn_controller_top #(
   parameter int ANGLE_BITS = dstc_pkg::ANGLE_BITS_DEF,
   parameter int SPEED_BITS = dstc_pkg::SPEED_BITS_DEF,
   localparam int IN_BITS   = 2 * ANGLE_BITS + 2 * SPEED_BITS,
   localparam int IN_W      = ((IN_BITS + 7) / 8) * 8,
   localparam int OUT_BITS  = 2 * (SPEED_BITS + 2),
   localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8,
   localparam int CSR_DATA_BITS = (SPEED_BITS > ANGLE_BITS - 1) ? SPEED_BITS : ANGLE_BITS - 1
) (
   input  logic                                clock,
   input  logic                                reset,
   // heading_angle, heading_length, obstacle_angle, obstacle_length (low first)
   input  logic [IN_W-1:0]                     req_tdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // left_speed, right_speed (low first), zero padded
   output logic [OUT_W-1:0]                    rsp_tdata,
   // mode_now, avoiding (low first)
   output logic [dstc_pkg::MODE_BITS:0]        rsp_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [dstc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]            csr_data
);
   import dstc_pkg::*;

   localparam int A = ANGLE_BITS;
   localparam int S = SPEED_BITS;

   dstc_cmd_type         cmd;
   dstc_status_type      status;
   logic signed [A-1:0]  heading_angle, obstacle_angle;
   logic [S-1:0]         heading_length, obstacle_length;
   logic signed [S+1:0]  left_speed, right_speed;
   logic [MODE_BITS-1:0] mode_now;
   logic                 avoiding;

   // registers never back-pressure
   assign csr_ready = 1'b1;

   // unpack the request beat
   assign heading_angle   = req_tdata[A-1:0];
   assign heading_length  = req_tdata[A+S-1:A];
   assign obstacle_angle  = req_tdata[2*A+S-1:A+S];
   assign obstacle_length = req_tdata[IN_BITS-1:2*A+S];

   // pack the response beat
   assign rsp_tdata = OUT_W'({right_speed, left_speed});
   assign rsp_tuser = {avoiding, mode_now};

   dstc_ctrl #(
      .DIV_STEPS (S + A)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   dstc_dp #(
      .ANGLE_BITS    (A),
      .SPEED_BITS    (S),
      .CSR_DATA_BITS (CSR_DATA_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_valid && csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .heading_angle   (heading_angle),
      .heading_length  (heading_length),
      .obstacle_angle  (obstacle_angle),
      .obstacle_length (obstacle_length),
      .cmd             (cmd),
      .status          (status),
      .left_speed      (left_speed),
      .right_speed     (right_speed),
      .mode_now        (mode_now),
      .avoiding        (avoiding)
   );

endmodule
